[src/quadratic_map_attractor_step_defines.svh]
// assertion macros for the quadratic map step block
// expects clk and arst_n in the scope of the module that uses them
`ifndef QUADRATIC_MAP_ATTRACTOR_STEP_DEFINES_SVH
`define QUADRATIC_MAP_ATTRACTOR_STEP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QMA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define QMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/qmap_pkg.sv]
// types, codes and control program for the quadratic map step block
// no dependencies
`default_nettype none

package qmap_pkg;

	// register file
	localparam int NumRegs = 7;
	localparam int RegIdxW = 3;
	localparam logic [RegIdxW-1:0] REG_COEF_A0_A1 = 3'd0;
	localparam logic [RegIdxW-1:0] REG_COEF_A2_A3 = 3'd1;
	localparam logic [RegIdxW-1:0] REG_COEF_A4_A5 = 3'd2;
	localparam logic [RegIdxW-1:0] REG_COEF_B0_B1 = 3'd3;
	localparam logic [RegIdxW-1:0] REG_COEF_B2_B3 = 3'd4;
	localparam logic [RegIdxW-1:0] REG_COEF_B4_B5 = 3'd5;
	localparam logic [RegIdxW-1:0] REG_START_POINT = 3'd6;
	localparam logic [63:0] COEF_RESET = 64'h0100_0000_0100_0000;
	localparam logic [63:0] START_RESET = 64'h0;

	// action codes
	localparam logic [1:0] ACT_STEP    = 2'd0;
	localparam logic [1:0] ACT_LOAD    = 2'd1;
	localparam logic [1:0] ACT_RESTORE = 2'd2;

	// sequencer
	localparam int StepW = 4;
	localparam logic [StepW-1:0] STEP_IDLE = 4'd0;
	localparam logic [StepW-1:0] STEP_LAST = 4'd15;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] load_x;
		logic signed [31:0] load_y;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] next_x;
		logic signed [31:0] next_y;
		logic               overflow;
	} out_beat_t;

	// multiplier operand selects
	typedef enum logic [2:0] {SA_X, SA_Y, SA_MXX, SA_MXY, SA_MYY} sel_a_t;
	typedef enum logic [2:0] {SB_X, SB_Y, SB_C1, SB_C2, SB_C3, SB_C4, SB_C5} sel_b_t;
	// what happens to the product of the previous step
	typedef enum logic [2:0] {PO_NONE, PO_MXX, PO_MXY, PO_MYY, PO_ACCA, PO_ACCB} post_t;
	// step counter update
	typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT} jump_t;

	typedef struct packed {
		sel_a_t            sel_a;
		sel_b_t            sel_b;
		logic              bank_b;
		post_t             post;
		jump_t             jmp;
		logic [StepW-1:0]  target;
	} ucode_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] val;
	} sat_t;

	// control program, one word per step
	function automatic ucode_t ucode(input logic [StepW-1:0] step);
		ucode_t uc;
		uc = '{SA_X, SB_X, 1'b0, PO_NONE, JMP_NEXT, STEP_IDLE};
		case (step)
			4'd0:  uc = '{SA_X,   SB_X,  1'b0, PO_NONE, JMP_WAIT_IN,  STEP_IDLE};
			4'd1:  uc = '{SA_X,   SB_X,  1'b0, PO_NONE, JMP_NEXT,     STEP_IDLE};
			4'd2:  uc = '{SA_X,   SB_Y,  1'b0, PO_MXX,  JMP_NEXT,     STEP_IDLE};
			4'd3:  uc = '{SA_Y,   SB_Y,  1'b0, PO_MXY,  JMP_NEXT,     STEP_IDLE};
			4'd4:  uc = '{SA_X,   SB_C1, 1'b0, PO_MYY,  JMP_NEXT,     STEP_IDLE};
			4'd5:  uc = '{SA_MXX, SB_C2, 1'b0, PO_ACCA, JMP_NEXT,     STEP_IDLE};
			4'd6:  uc = '{SA_MXY, SB_C3, 1'b0, PO_ACCA, JMP_NEXT,     STEP_IDLE};
			4'd7:  uc = '{SA_Y,   SB_C4, 1'b0, PO_ACCA, JMP_NEXT,     STEP_IDLE};
			4'd8:  uc = '{SA_MYY, SB_C5, 1'b0, PO_ACCA, JMP_NEXT,     STEP_IDLE};
			4'd9:  uc = '{SA_X,   SB_C1, 1'b1, PO_ACCA, JMP_NEXT,     STEP_IDLE};
			4'd10: uc = '{SA_MXX, SB_C2, 1'b1, PO_ACCB, JMP_NEXT,     STEP_IDLE};
			4'd11: uc = '{SA_MXY, SB_C3, 1'b1, PO_ACCB, JMP_NEXT,     STEP_IDLE};
			4'd12: uc = '{SA_Y,   SB_C4, 1'b1, PO_ACCB, JMP_NEXT,     STEP_IDLE};
			4'd13: uc = '{SA_MYY, SB_C5, 1'b1, PO_ACCB, JMP_NEXT,     STEP_IDLE};
			4'd14: uc = '{SA_X,   SB_X,  1'b0, PO_ACCB, JMP_NEXT,     STEP_IDLE};
			4'd15: uc = '{SA_X,   SB_X,  1'b0, PO_NONE, JMP_WAIT_OUT, STEP_IDLE};
			default: uc = '{SA_X, SB_X,  1'b0, PO_NONE, JMP_NEXT,     STEP_IDLE};
		endcase
		return uc;
	endfunction

	// clamp a value already scaled to Q8.24 into 32 bits
	function automatic sat_t sat32(input logic signed [43:0] v);
		sat_t r;
		r.ovf = 1'b0;
		r.val = v[31:0];
		if ((v[43:31] != {13{1'b0}}) && (v[43:31] != {13{1'b1}})) begin
			r.ovf = 1'b1;
			r.val = v[43] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[src/quadratic_map_attractor_step.sv]
// one iteration of the general 2-d quadratic map per step beat
// depends on qmap_pkg and quadratic_map_attractor_step_defines.svh
//
// channel   dir  handshake           payload
// in        in   in_valid/in_ready   qmap_pkg::in_beat_t  (action, load_x, load_y)
// out       out  out_valid/out_ready qmap_pkg::out_beat_t (next_x, next_y, overflow)
// cfg       in   cfg_we              cfg_idx (3 bits), cfg_data (64 bits)
//
// a step beat runs program steps 1 to 15 on the one shared 32x32
// multiplier, after the idle step that takes the beat
// load and restore beats are taken in the idle step and give no output beat
// output is registered; a full output register stalls only the last step
// arst_n clears the point, the start point and the output valid and sets every coefficient to 1.0
`default_nettype none

`include "quadratic_map_attractor_step_defines.svh"

module quadratic_map_attractor_step (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire qmap_pkg::in_beat_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output qmap_pkg::out_beat_t                out_data,
	input  wire logic                          cfg_we,
	input  wire logic [qmap_pkg::RegIdxW-1:0]  cfg_idx,
	input  wire logic [63:0]                   cfg_data
);
	import qmap_pkg::*;

	logic [63:0]        cfg_q [NumRegs];
	logic signed [31:0] pt_x_q, pt_y_q;
	logic [StepW-1:0]   step_q, step_d;
	logic signed [63:0] prod_q;
	logic signed [31:0] mxx_q, mxy_q, myy_q;
	logic signed [67:0] acc_a_q, acc_b_q;
	logic               ovf_q;
	logic               out_valid_q;
	out_beat_t          out_q;

	ucode_t             uc;
	logic               in_fire, step_start, out_free, finish;
	logic signed [31:0] mul_a, mul_b;
	logic [63:0]        bank_lo, bank_mid, bank_hi;
	logic signed [64:0] mono_sum;
	sat_t               mono_sat, fin_x, fin_y;
	logic signed [67:0] prod_ext;
	logic signed [67:0] acc_init_a, acc_init_b;

	assign uc         = ucode(step_q);
	assign in_ready   = (step_q == STEP_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign step_start = in_fire && (in_data.action == ACT_STEP);
	assign out_free   = !out_valid_q || out_ready;
	assign finish     = (uc.jmp == JMP_WAIT_OUT) && out_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) begin
				cfg_q[i] <= (i == int'(REG_START_POINT)) ? START_RESET : COEF_RESET;
			end
		end else if (cfg_we && (cfg_idx < RegIdxW'(NumRegs))) begin
			cfg_q[cfg_idx] <= cfg_data;
		end
	end

	// step counter with conditional jumps
	always_comb begin
		case (uc.jmp)
			JMP_WAIT_IN:  step_d = step_start ? StepW'(step_q + 1'b1) : step_q;
			JMP_WAIT_OUT: step_d = out_free ? uc.target : step_q;
			default:      step_d = StepW'(step_q + 1'b1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// operand selection for the shared multiplier
	assign bank_lo  = uc.bank_b ? cfg_q[REG_COEF_B0_B1] : cfg_q[REG_COEF_A0_A1];
	assign bank_mid = uc.bank_b ? cfg_q[REG_COEF_B2_B3] : cfg_q[REG_COEF_A2_A3];
	assign bank_hi  = uc.bank_b ? cfg_q[REG_COEF_B4_B5] : cfg_q[REG_COEF_A4_A5];

	always_comb begin
		case (uc.sel_a)
			SA_X:    mul_a = pt_x_q;
			SA_Y:    mul_a = pt_y_q;
			SA_MXX:  mul_a = mxx_q;
			SA_MXY:  mul_a = mxy_q;
			SA_MYY:  mul_a = myy_q;
			default: mul_a = pt_x_q;
		endcase
		case (uc.sel_b)
			SB_X:    mul_b = pt_x_q;
			SB_Y:    mul_b = pt_y_q;
			SB_C1:   mul_b = bank_lo[31:0];
			SB_C2:   mul_b = bank_mid[63:32];
			SB_C3:   mul_b = bank_mid[31:0];
			SB_C4:   mul_b = bank_hi[63:32];
			SB_C5:   mul_b = bank_hi[31:0];
			default: mul_b = pt_x_q;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// rounding of the previous product and the final sums
	assign mono_sum   = {prod_q[63], prod_q} + 65'sh80_0000;
	assign mono_sat   = sat32({{3{mono_sum[64]}}, mono_sum[64:24]});
	assign prod_ext   = {{4{prod_q[63]}}, prod_q};
	// a0 in Q20.48 plus half an lsb of Q8.24
	assign acc_init_a = {{12{cfg_q[REG_COEF_A0_A1][63]}}, cfg_q[REG_COEF_A0_A1][63:32],
		1'b1, 23'b0};
	assign acc_init_b = {{12{cfg_q[REG_COEF_B0_B1][63]}}, cfg_q[REG_COEF_B0_B1][63:32],
		1'b1, 23'b0};
	assign fin_x      = sat32(acc_a_q[67:24]);
	assign fin_y      = sat32(acc_b_q[67:24]);

	// monomials, accumulators and the overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (step_start) begin
			ovf_q <= 1'b0;
		end else if ((uc.post == PO_MXX) || (uc.post == PO_MXY) || (uc.post == PO_MYY)) begin
			ovf_q <= ovf_q | mono_sat.ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (step_start) begin
			acc_a_q <= acc_init_a;
			acc_b_q <= acc_init_b;
		end else begin
			case (uc.post)
				PO_MXX:  mxx_q   <= mono_sat.val;
				PO_MXY:  mxy_q   <= mono_sat.val;
				PO_MYY:  myy_q   <= mono_sat.val;
				PO_ACCA: acc_a_q <= acc_a_q + prod_ext;
				PO_ACCB: acc_b_q <= acc_b_q + prod_ext;
				default: ;
			endcase
		end
	end

	// stored point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_x_q <= '0;
			pt_y_q <= '0;
		end else if (finish) begin
			pt_x_q <= fin_x.val;
			pt_y_q <= fin_y.val;
		end else if (in_fire && (in_data.action == ACT_LOAD)) begin
			pt_x_q <= in_data.load_x;
			pt_y_q <= in_data.load_y;
		end else if (in_fire && (in_data.action == ACT_RESTORE)) begin
			pt_x_q <= cfg_q[REG_START_POINT][63:32];
			pt_y_q <= cfg_q[REG_START_POINT][31:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.next_x   <= fin_x.val;
			out_q.next_y   <= fin_y.val;
			out_q.overflow <= ovf_q | fin_x.ovf | fin_y.ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a step beat starts the program at its first working step
	`QMA_ASSERT_NEXT(a_step_starts, step_start, step_q == 4'd1, "step beat did not start program")
	// a new output beat only comes from the last program step
	`QMA_ASSERT_SAME(a_out_from_last, $rose(out_valid_q), $past(step_q) == STEP_LAST,
		"output beat raised outside the last step")
	// the point holds while the program reads it
	`QMA_ASSERT_NEXT(a_point_held, (step_q != STEP_IDLE) && !finish,
		$stable(pt_x_q) && $stable(pt_y_q), "point changed during a step")

endmodule

`default_nettype wire
